// File: sv/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// Types and codes shared by the bucketed hash set and its parts.
// ----------------------------------------------------------------------------
package bhs_pkg;

  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int BIDX_W   = 4;
  localparam int SIDX_W   = 3;

  typedef enum logic {
    OP_FIND   = 1'b0,
    OP_INSERT = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [BIDX_W-1:0] bucket_index;
    logic [SIDX_W-1:0] slot_index;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_MOD,
    S_READ,
    S_CMP
  } state_t;

endpackage

// File: sv/bhs_ram.sv
// ----------------------------------------------------------------------------
// bhs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/bucketed_hash_set.sv
// ----------------------------------------------------------------------------
// bucketed_hash_set
// Set of non-negative keys in BUCKETS buckets of WAYS slots, bucket chosen
// as key modulo BUCKETS; find or insert one key per transaction.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  --------+-------------------------------+-----------------------------------
//  input   | in_valid, in_ready, in_data   | opcode, key
//  result  | out_valid, out_ready, out_data| status, bucket_index, slot_index
//
//  Each transaction steps through accept, reciprocal multiply, modulo
//  subtract, bucket row read, compare and write back.
//  One bucket row (fill count and all slot keys) is one RAM word.
//  After reset a clearing pass writes a zero fill to every row, during
//  which in_ready stays low.
//  A stalled result waits in the output register; a new transaction is
//  accepted meanwhile and holds in the compare step until the register frees.
// ----------------------------------------------------------------------------
module bucketed_hash_set #(
  parameter int BUCKETS = 10,
  parameter int WAYS    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bhs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bhs_pkg::out_t out_data
);

  import bhs_pkg::*;

  localparam int BW     = $clog2(BUCKETS);
  localparam int FW     = $clog2(WAYS + 1);
  localparam int SW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W  = FW + WAYS * KEY_W;
  localparam int SHIFT  = KEY_W + BW;
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) / BUCKETS) + 64'd1;
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [KEY_W-1:0] BUCKETS_K = KEY_W'(BUCKETS);
  localparam logic [BW-1:0]    LAST_ROW  = BW'(BUCKETS - 1);

  state_t           state_r, state_nxt;
  opcode_t          op_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] q_r;
  logic [BW-1:0]    bucket_r;
  logic [BW-1:0]    clr_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic [62:0]      prod;
  logic [KEY_W-1:0] q_nxt;
  logic [KEY_W-1:0] qb;
  logic [KEY_W-1:0] rem;

  logic             ram_we, ram_re;
  logic [BW-1:0]    ram_wa, ram_ra;
  logic [ROW_W-1:0] ram_wd, rd_row;

  logic [FW-1:0]    fill;
  logic [WAYS-1:0]  hit;
  logic [SW-1:0]    hit_slot;
  logic             any_hit, full, do_write, out_free, finish;
  logic [ROW_W-1:0] new_row;
  out_t             res;
  logic [SW+SIDX_W-1:0] slot_ext;
  logic [BW+BIDX_W-1:0] bucket_ext;
  logic [SW-1:0]    res_slot;

  bhs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (rd_row)
  );

  assign prod  = {32'b0, key_r} * {31'b0, RECIP};
  assign q_nxt = KEY_W'(prod >> SHIFT);
  assign qb    = KEY_W'(q_r * BUCKETS_K);
  assign rem   = key_r - qb;

  always_comb begin
    fill     = rd_row[ROW_W-1 -: FW];
    hit      = '0;
    hit_slot = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = (FW'(w) < fill) && (rd_row[w*KEY_W +: KEY_W] == key_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_slot = SW'(w);
      end
    end
    any_hit = |hit;
    full    = (fill >= FW'(WAYS));
    new_row = rd_row;
    new_row[ROW_W-1 -: FW] = fill + FW'(1);
    for (int w = 0; w < WAYS; w++) begin
      if (SW'(w) == fill[SW-1:0]) begin
        new_row[w*KEY_W +: KEY_W] = key_r;
      end
    end
  end

  always_comb begin
    do_write = 1'b0;
    res_slot = '0;
    if (any_hit) begin
      res.status = (op_r == OP_INSERT) ? ST_DUPLICATE : ST_OK;
      res_slot   = hit_slot;
    end else if (op_r == OP_FIND) begin
      res.status = ST_NOT_FOUND;
    end else if (full) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_OK;
      res_slot   = fill[SW-1:0];
      do_write   = 1'b1;
    end
    slot_ext         = {{SIDX_W{1'b0}}, res_slot};
    bucket_ext       = {{BIDX_W{1'b0}}, bucket_r};
    res.slot_index   = slot_ext[SIDX_W-1:0];
    res.bucket_index = bucket_ext[BIDX_W-1:0];
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == LAST_ROW) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_MOD;
      S_MOD:   state_nxt = S_READ;
      S_READ:  state_nxt = S_CMP;
      S_CMP:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    ram_we   = 1'b0;
    ram_wa   = bucket_r;
    ram_wd   = new_row;
    ram_re   = 1'b0;
    ram_ra   = bucket_r;
    in_ready = 1'b0;
    finish   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_r;
        ram_wd = '0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_CMP: begin
        finish = out_free;
        ram_we = out_free && do_write;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_valid && in_ready) begin
      op_r  <= in_data.opcode;
      key_r <= in_data.key;
    end
    if (state_r == S_MUL) begin
      q_r <= q_nxt;
    end
    if (state_r == S_MOD) begin
      bucket_r <= rem[BW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL))
    else $error("accepted transaction did not advance to multiply");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (bucket_r < BW'(BUCKETS - 1) || bucket_r == LAST_ROW))
    else $error("bucket index out of range");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> $onehot0(hit))
    else $error("key held in more than one slot");

  a_write_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != S_CLEAR) |->
      (op_r == OP_INSERT && res.status == ST_OK && !full && finish))
    else $error("row written without a successful insert");
`endif

endmodule
